### rtl/efsd_pkg.sv
// Package for the earliest-free server dispatch block: sizes, beat types and helpers.
package efsd_pkg;

  localparam int WINDOWS      = 8;
  localparam int WIN_W        = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int CNT_W        = $clog2(WINDOWS + 1);
  localparam int MIN_PER_HOUR = 60;
  localparam int RECIP_60     = 34953;
  localparam int RECIP_SHIFT  = 21;
  localparam int HOUR_W       = 11;
  localparam int MINUTE_W     = 6;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic       new_batch;
    logic [4:0] arr_hour;
    logic [5:0] arr_minute;
    logic [7:0] service_minutes;
  } job_t;

  typedef struct packed {
    logic [15:0] customer_index;
    logic [2:0]  window_index;
    logic [15:0] wait_minutes;
    logic [10:0] start_hour;
    logic [5:0]  start_minute;
    logic [15:0] window_served;
  } res_t;

  typedef struct packed {
    logic [15:0] busy;
    logic [15:0] served;
  } win_entry_t;

  typedef struct packed {
    logic                valid;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } split_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == SAT16) ? SAT16 : v + 16'd1;
  endfunction

endpackage

### rtl/efsd_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module efsd_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/efsd_time_split.sv
// Two-stage split of a minute count into hour and minute by reciprocal multiply.
module efsd_time_split (
  input  logic          clk,
  input  logic          rst,
  input  logic          start_valid,
  input  logic [15:0]   start_min,
  output efsd_pkg::split_t split
);
  import efsd_pkg::*;

  logic        valid_a;
  logic [15:0] start_a;
  logic [31:0] prod_a;
  logic [HOUR_W-1:0] hour_a;
  logic              valid_b;
  logic [HOUR_W-1:0] hour_b;
  logic [MINUTE_W-1:0] minute_b;

  assign hour_a = prod_a[RECIP_SHIFT +: HOUR_W];
  assign split  = '{valid: valid_b, hour: hour_b, minute: minute_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      valid_a <= start_valid;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (start_valid) begin
      start_a <= start_min;
      prod_a  <= 32'(start_min) * 32'(RECIP_60);
    end
    if (valid_a) begin
      hour_b   <= hour_a;
      minute_b <= MINUTE_W'(start_a - 16'(hour_a) * 16'(MIN_PER_HOUR));
    end
  end

endmodule

### rtl/earliest_free_server_dispatch.sv
// Top level of the earliest-free server dispatch block.
//
// Usage: jobs arrive on the job channel (job_valid / job_stall), one beat
// per job, already in arrival order. A job with nonzero service gives one
// beat on the res channel (res_valid / res_stall); a job with zero service
// gives none. The user writes the server count on the cfg channel (cfg_valid /
// cfg_ready, always ready) while the block is idle; the block does not enforce it.
// Per-server busy-until times and served counts live in one RAM with a
// registered read; the scan reads one server a cycle to find the earliest.
// A served job passes from acceptance through the scan of the servers in
// use (1 to WINDOWS), an update state that writes the chosen server back,
// and the hour/minute split, with the result loaded once the split is done
// and the output register is free; the block then returns to idle, where
// the next job is taken. A skipped job does not leave the idle state.
// new_batch clears per-server valid bits at once, so no clearing pass is
// needed.
// Reset: server count 1, all times and counts zero, result register empty.
// A stalled result is held in the output register; the next job is still
// taken and worked on, and waits at its end until the register is free.
module earliest_free_server_dispatch (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_stall,
  input  efsd_pkg::job_t  job,
  output logic            res_valid,
  input  logic            res_stall,
  output efsd_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data
);
  import efsd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state;
  logic [3:0]         window_count;
  logic [CNT_W-1:0]   count_eff;
  job_t               job_q;
  logic [WINDOWS-1:0] valid_bits;
  logic [15:0]        served_total;
  logic [CNT_W-1:0]   issue_idx;
  logic               pend;
  logic [WIN_W-1:0]   pend_idx;
  logic [WIN_W-1:0]   best;
  logic [15:0]        best_busy;
  logic [15:0]        best_served;
  logic [15:0]        wait_q;
  logic [15:0]        served_q;

  logic               rd_en;
  logic [WIN_W-1:0]   rd_addr;
  win_entry_t         rd_data;
  logic               wr_en;
  win_entry_t         wr_data;

  logic [15:0]        cand_busy;
  logic [15:0]        cand_served;
  logic [15:0]        arrival;
  logic [15:0]        start_min;
  logic [16:0]        end_min;
  logic               accept;
  logic               out_free;
  logic               res_load;
  logic               scan_last;
  split_t             split;

  assign cfg_ready = 1'b1;
  assign job_stall = (state != S_IDLE);
  assign accept    = job_valid && !job_stall;
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = (state == S_DIV && split.valid && out_free) || (state == S_OUT && out_free);

  always_comb begin
    if (window_count == 4'd0) begin
      count_eff = CNT_W'(1);
    end else if (32'(window_count) > WINDOWS) begin
      count_eff = CNT_W'(WINDOWS);
    end else begin
      count_eff = CNT_W'(window_count);
    end
  end

  assign rd_en   = (state == S_SCAN) && (issue_idx < count_eff);
  assign rd_addr = issue_idx[WIN_W-1:0];

  assign cand_busy   = valid_bits[pend_idx] ? rd_data.busy : 16'd0;
  assign cand_served = valid_bits[pend_idx] ? rd_data.served : 16'd0;
  assign scan_last   = pend && (CNT_W'(pend_idx) == count_eff - CNT_W'(1));

  assign arrival   = 16'(job_q.arr_hour) * 16'(MIN_PER_HOUR) + 16'(job_q.arr_minute);
  assign start_min = (best_busy > arrival) ? best_busy : arrival;
  assign end_min   = 17'(start_min) + 17'(job_q.service_minutes);

  assign wr_en          = (state == S_START);
  assign wr_data.busy   = end_min[16] ? SAT16 : end_min[15:0];
  assign wr_data.served = sat_inc16(best_served);

  efsd_ram #(
    .DEPTH(WINDOWS),
    .WIDTH($bits(win_entry_t))
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(best),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  efsd_time_split u_split (
    .clk        (clk),
    .rst        (rst),
    .start_valid(wr_en),
    .start_min  (start_min),
    .split      (split)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= 4'd1;
    end else if (cfg_valid) begin
      window_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid_bits   <= '0;
      served_total <= 16'd0;
      issue_idx    <= '0;
      pend         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      pend <= rd_en;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (job.new_batch) begin
              valid_bits   <= '0;
              served_total <= 16'd0;
            end
            issue_idx <= '0;
            if (job.service_minutes != 8'd0) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (scan_last) begin
            state <= S_START;
          end
        end
        S_START: begin
          valid_bits[best] <= 1'b1;
          served_total     <= sat_inc16(served_total);
          state            <= S_DIV;
        end
        S_DIV: begin
          if (split.valid) begin
            if (out_free) begin
              state <= S_IDLE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_q <= job;
    end
    pend_idx <= rd_addr;
    if (state == S_SCAN && pend && (pend_idx == '0 || cand_busy < best_busy)) begin
      best        <= pend_idx;
      best_busy   <= cand_busy;
      best_served <= cand_served;
    end
    if (state == S_START) begin
      wait_q   <= start_min - arrival;
      served_q <= wr_data.served;
    end
    if (res_load) begin
      res.customer_index <= served_total;
      res.window_index   <= 3'(best);
      res.wait_minutes   <= wait_q;
      res.start_hour     <= split.hour;
      res.start_minute   <= split.minute;
      res.window_served  <= served_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_START |-> CNT_W'(best) < count_eff)
    else $error("chosen server beyond servers in use");

  a_split_latency: assert property (@(posedge clk) disable iff (rst)
    state == S_START |-> ##2 split.valid)
    else $error("hour/minute split not ready two cycles after launch");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    accept && job.new_batch |=> served_total == 16'd0 && valid_bits == '0)
    else $error("new batch did not clear state");

  a_counts_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.customer_index != 16'd0 && res.window_served != 16'd0)
    else $error("result beat with zero count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_idx <= count_eff)
    else $error("scan ran past servers in use");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the earliest-free server dispatch block.
module testbench;
  import efsd_pkg::*;

  localparam int HOLD_OFF       = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE         = 20;
  localparam int PHASE_JOBS     = 43;
  localparam int SAT_JOBS       = 260;
  localparam int DAY_MINUTES    = 1440;

  class dispatch_scoreboard;
    logic [15:0] busy_until [WINDOWS];
    logic [15:0] served_by [WINDOWS];
    logic [15:0] served_total;
    logic [3:0]  window_count;
    res_t        expected_q [$];
    int          mismatches;
    int          jobs;
    int          skipped;
    int          results;

    function new();
      window_count = 4'd1;
      mismatches   = 0;
      jobs         = 0;
      skipped      = 0;
      results      = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      foreach (busy_until[k]) begin
        busy_until[k] = '0;
        served_by[k]  = '0;
      end
      served_total = '0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function string show(res_t r);
      return $sformatf("cust=%0d win=%0d wait=%0d start=%0d:%0d served=%0d",
                       r.customer_index, r.window_index, r.wait_minutes,
                       r.start_hour, r.start_minute, r.window_served);
    endfunction

    // works out the dispatch of one accepted job
    function void note_job(job_t j);
      int unsigned in_use;
      int unsigned best;
      int unsigned arrival;
      int unsigned start_t;
      int unsigned finish;
      res_t        r;
      jobs++;
      if (j.new_batch) clear_batch();
      if (j.service_minutes == 8'd0) begin
        skipped++;
        return;
      end
      if (window_count == 4'd0) in_use = 1;
      else if (window_count > WINDOWS) in_use = WINDOWS;
      else in_use = 32'(window_count);
      best = 0;
      for (int k = 1; k < in_use; k++) begin
        if (busy_until[k] < busy_until[best]) best = k;
      end
      served_total    = bump(served_total);
      served_by[best] = bump(served_by[best]);
      arrival = j.arr_hour * MIN_PER_HOUR + j.arr_minute;
      start_t = (busy_until[best] > arrival) ? busy_until[best] : arrival;
      finish  = start_t + j.service_minutes;
      busy_until[best] = (finish > 65535) ? 16'hFFFF : finish[15:0];
      r.customer_index = served_total;
      r.window_index   = best[2:0];
      r.wait_minutes   = 16'(start_t - arrival);
      r.start_hour     = 11'(start_t / MIN_PER_HOUR);
      r.start_minute   = 6'(start_t % MIN_PER_HOUR);
      r.window_served  = served_by[best];
      expected_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat %0d with none expected: %s", results, show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.customer_index !== want.customer_index || got.window_index !== want.window_index ||
          got.wait_minutes !== want.wait_minutes || got.start_hour !== want.start_hour ||
          got.start_minute !== want.start_minute || got.window_served !== want.window_served) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d mismatch: expected %s, got %s", results, show(want), show(got));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       job_valid = 1'b0;
  logic       job_stall;
  job_t       job       = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_t       res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data  = '0;

  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_req       = 1'b0;
  int idle_cycles    = 0;
  int arrival_clock  = 0;
  int cfg_writes     = 0;

  logic [3:0] phase_cfg [10] = '{4'd15, 4'd0, 4'd1, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};

  dispatch_scoreboard sb = new;

  earliest_free_server_dispatch u_dut (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(res);
      if (job_valid && !job_stall) sb.note_job(job);
      if (cfg_valid && cfg_ready) begin
        sb.window_count = cfg_data;
        cfg_writes++;
      end
      if ((res_valid && !res_stall) || (job_valid && !job_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result-side stall bursts, plus the long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        hold_req = 1'b0;
        repeat (HOLD_OFF - 1) @(negedge clk);
      end else if (!receiver_quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 11);
        res_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = receiver_quiet ? 1 : $urandom_range(1, 30);
        res_stall <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_job(input job_t j);
    int gap;
    if (!sender_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      job_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    job_valid <= 1'b1;
    job       <= j;
    @(posedge clk);
    while (job_stall) @(posedge clk);
  endtask

  task automatic wait_all_served();
    @(negedge clk);
    job_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window_count(input logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-order arrivals within a day, some arbitrary field noise
  function automatic job_t make_job();
    job_t j;
    int   pick;
    pick = $urandom_range(0, 99);
    j.new_batch = (pick < 4);
    if (pick < 85) begin
      if (j.new_batch) arrival_clock = $urandom_range(0, 120);
      else arrival_clock += $urandom_range(0, 20);
      if (arrival_clock >= DAY_MINUTES) begin
        j.new_batch   = 1'b1;
        arrival_clock = $urandom_range(0, 60);
      end
      j.arr_hour   = 5'(arrival_clock / 60);
      j.arr_minute = 6'(arrival_clock % 60);
    end else begin
      j.arr_hour   = 5'($urandom);
      j.arr_minute = 6'($urandom);
    end
    if ($urandom_range(0, 9) == 0) j.service_minutes = 8'd0;
    else if ($urandom_range(0, 4) == 0) j.service_minutes = 8'($urandom_range(1, 255));
    else j.service_minutes = 8'($urandom_range(1, 60));
    return j;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_window_count(4'd8);
    send_job(job_t'{1'b1, 5'd0, 6'd0, 8'd1});
    send_job(job_t'{1'b0, 5'd0, 6'd0, 8'd255});
    send_job(job_t'{1'b0, 5'd0, 6'd0, 8'd0});
    repeat (7) send_job(job_t'{1'b0, 5'd0, 6'd0, 8'd10});   // ties among the still-idle servers
    send_job(job_t'{1'b0, 5'd23, 6'd59, 8'd255});
    send_job(job_t'{1'b0, 5'd31, 6'd63, 8'd255});
    send_job(job_t'{1'b0, 5'd24, 6'd60, 8'd128});
    send_job(job_t'{1'b1, 5'd5, 6'd5, 8'd0});             // clear on a skipped job
    send_job(job_t'{1'b0, 5'd0, 6'd0, 8'd1});
    send_job(job_t'{1'b0, 5'd0, 6'd30, 8'd85});
    send_job(job_t'{1'b0, 5'd21, 6'd42, 8'd170});
    send_job(job_t'{1'b0, 5'd10, 6'd21, 8'd85});
    wait_all_served();

    foreach (phase_cfg[p]) begin
      write_window_count(phase_cfg[p]);
      for (int i = 0; i < PHASE_JOBS; i++) begin
        if (p == 2 && i == PHASE_JOBS / 2) hold_req = 1'b1;
        if (p == 4 && i == PHASE_JOBS / 2) wait_all_served();
        send_job(make_job());
      end
      wait_all_served();
    end

    // no idling from here on
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;

    // long single-server batch drives the busy time into saturation
    write_window_count(4'd0);
    send_job(job_t'{1'b1, 5'd23, 6'd59, 8'd255});
    repeat (SAT_JOBS)
      send_job(job_t'{1'b0, 5'($urandom), 6'($urandom), 8'd255});
    wait_all_served();

    write_window_count(4'd8);
    for (int i = 0; i < PHASE_JOBS; i++) send_job(make_job());
    wait_all_served();

    $display("Run covered %0d jobs (%0d skipped) and %0d checked results over %0d server-count writes.",
             sb.jobs, sb.skipped, sb.results, cfg_writes);
    $display("Server counts 0 to 9 and 15, ties, odd arrivals, busy-time saturation, hold-off, drain.");
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches > 10) $display("%0d mismatches in total", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
